[sv/fhs_pkg.sv]
// shared types, constants and helpers for the frame histogram / sad engine
// no dependencies
`timescale 1ns / 1ps

package fhs_pkg;

  localparam int HIST_BINS = 256;
  localparam int DIFF_BINS = 512;
  // two bins per memory row, two sets
  localparam int HIST_ROWS = HIST_BINS;
  localparam int DIFF_ROWS = DIFF_BINS;
  localparam int CLR_CNT_W = $clog2(DIFF_ROWS);
  localparam int DEFAULT_CMD_DEPTH = 2;
  localparam int RES_DEPTH = 2;

  localparam logic CFG_TEN_BIT = 1'b0;
  localparam logic CFG_CHROMA  = 1'b1;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_SAMPLE = 2'd1,
    REQ_READ   = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_SAMPLE,
    OP_READ
  } op_e;

  typedef enum logic [1:0] {
    RG_SRC,
    RG_REF,
    RG_DIF,
    RG_ZERO
  } region_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD,
    ST_RD
  } state_e;

  typedef struct packed {
    op_e           op;
    logic          set;
    logic [7:0]    src_row;
    logic          src_hi;
    logic [7:0]    ref_row;
    logic          ref_hi;
    logic [8:0]    dif_row;
    logic          dif_hi;
    logic [7:0]    abs_diff;
    region_e       region;
    logic [8:0]    rd_row;
    logic          rd_sad;
  } cmd_t;

  typedef struct packed {
    logic clearing;
    logic cmd_pop;
  } back_stat_t;

  function automatic logic [7:0] to_eight(input logic [9:0] v, input logic ten);
    logic [10:0] x;
    x = ten ? ((({1'b0, v}) + 11'd2) >> 2) : {1'b0, v};
    return (x > 11'd255) ? 8'd255 : x[7:0];
  endfunction

endpackage

[sv/fhs_front.sv]
// front part: classifies requests into commands and queues them for the back part
// depends on fhs_pkg
`timescale 1ns / 1ps

module fhs_front import fhs_pkg::*; #(
  parameter int CmdDepth = DEFAULT_CMD_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       ten_bit_i,
  input  logic       chroma_i,
  input  logic       push_i,
  output logic       full_o,
  input  logic [1:0] req_type_i,
  input  logic [9:0] src_sample_i,
  input  logic [9:0] ref_sample_i,
  input  logic       component_i,
  input  logic [9:0] word_index_i,
  input  back_stat_t stat_i,
  output logic       cmd_valid_o,
  output cmd_t       cmd_o
);

  localparam int PtrW = (CmdDepth > 1) ? $clog2(CmdDepth) : 1;
  localparam int CntW = $clog2(CmdDepth + 1);

  cmd_t            fifo_q [CmdDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            q_full, q_push, q_pop;
  cmd_t            cmd;
  logic [7:0]      s8, r8;
  logic [8:0]      dif;
  logic            set;
  req_e            req;

  always_comb begin
    req = req_e'(req_type_i);
    set = chroma_i & component_i;
    s8  = to_eight(src_sample_i, ten_bit_i);
    r8  = to_eight(ref_sample_i, ten_bit_i);
    // offset difference, wraps into the 512-bin range
    dif = {1'b0, s8} - {1'b0, r8} + 9'd256;

    cmd.op       = OP_SAMPLE;
    cmd.set      = set;
    cmd.src_row  = {set, s8[7:1]};
    cmd.src_hi   = s8[0];
    cmd.ref_row  = {set, r8[7:1]};
    cmd.ref_hi   = r8[0];
    cmd.dif_row  = {set, dif[8:1]};
    cmd.dif_hi   = dif[0];
    cmd.abs_diff = (s8 >= r8) ? (s8 - r8) : (r8 - s8);
    cmd.region   = RG_ZERO;
    cmd.rd_row   = '0;
    cmd.rd_sad   = 1'b0;

    unique case (req)
      REQ_CLEAR:  cmd.op = OP_CLEAR;
      REQ_SAMPLE: cmd.op = OP_SAMPLE;
      REQ_READ:   cmd.op = OP_READ;
      default:    cmd.op = OP_SAMPLE;
    endcase

    // read layout: source, reference, difference words
    if (chroma_i) begin
      if (word_index_i[9:8] == 2'd0) begin
        cmd.region = RG_SRC;
        cmd.rd_row = {1'b0, word_index_i[7:0]};
      end else if (word_index_i[9:8] == 2'd1) begin
        cmd.region = RG_REF;
        cmd.rd_row = {1'b0, word_index_i[7:0]};
      end else begin
        cmd.region = RG_DIF;
        cmd.rd_row = word_index_i[8:0];
        cmd.rd_sad = (word_index_i[7:0] == 8'd0);
      end
    end else begin
      if (word_index_i[9:7] == 3'd0) begin
        cmd.region = RG_SRC;
        cmd.rd_row = {2'b0, word_index_i[6:0]};
      end else if (word_index_i[9:7] == 3'd1) begin
        cmd.region = RG_REF;
        cmd.rd_row = {2'b0, word_index_i[6:0]};
      end else if (word_index_i[9:8] == 2'd1) begin
        cmd.region = RG_DIF;
        cmd.rd_row = {1'b0, word_index_i[7:0]};
        cmd.rd_sad = (word_index_i[7:0] == 8'd0);
      end
    end
  end

  assign q_full = (cnt_q == CntW'(CmdDepth));
  assign full_o = q_full | stat_i.clearing;
  // unused request code is accepted and dropped
  assign q_push = push_i & ~full_o & (req != REQ_NONE);
  assign q_pop  = stat_i.cmd_pop & (cnt_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (q_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(CmdDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(CmdDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({q_push, q_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_push) begin
      fifo_q[wr_ptr_q] <= cmd;
    end
  end

  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = fifo_q[rd_ptr_q];

endmodule

[sv/fhs_back.sv]
// back part: histogram memories, sad sums, clearing sweep and result queue
// depends on fhs_pkg
`timescale 1ns / 1ps

module fhs_back import fhs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  input  cmd_t        cmd_i,
  output back_stat_t  stat_o,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [63:0] packed_word_o,
  output logic        res_push_o,
  output logic        res_full_o
);

  localparam int ResPtrW = $clog2(RES_DEPTH);
  localparam int ResCntW = $clog2(RES_DEPTH + 1);

  logic [63:0] src_mem [HIST_ROWS];
  logic [63:0] ref_mem [HIST_ROWS];
  logic [63:0] dif_mem [DIFF_ROWS];
  logic [63:0] src_rd_q, ref_rd_q, dif_rd_q;
  logic [31:0] sad_q [2];

  state_e state_q, state_d;
  cmd_t   cur_q;
  logic [CLR_CNT_W-1:0] clr_q, clr_d;

  logic        take;
  logic [7:0]  src_ra, ref_ra;
  logic [8:0]  dif_ra;
  logic        src_we, ref_we, dif_we;
  logic [7:0]  src_wa, ref_wa;
  logic [8:0]  dif_wa;
  logic [63:0] src_wd, ref_wd, dif_wd;
  logic        sad_clr, sad_add;
  logic [63:0] res_word;
  logic        res_push, res_pop, res_full;

  logic [63:0]        res_q [RES_DEPTH];
  logic [ResPtrW-1:0] res_wp_q, res_rp_q;
  logic [ResCntW-1:0] res_cnt_q;

  // reads wait for room in the result queue
  assign take = cmd_valid_i & ((cmd_i.op != OP_READ) | ~res_full);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_q == CLR_CNT_W'(DIFF_ROWS - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (take) begin
          unique case (cmd_i.op)
            OP_CLEAR:  state_d = ST_CLEAR;
            OP_SAMPLE: state_d = ST_UPD;
            OP_READ:   state_d = ST_RD;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_UPD:  state_d = ST_IDLE;
      ST_RD:   state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  function automatic logic [63:0] bump(input logic [63:0] row, input logic hi);
    logic [63:0] r;
    r = row;
    if (hi) r[63:32] = row[63:32] + 32'd1;
    else    r[31:0]  = row[31:0] + 32'd1;
    return r;
  endfunction

  always_comb begin
    stat_o.clearing = 1'b0;
    stat_o.cmd_pop  = 1'b0;
    clr_d    = clr_q;
    src_ra   = cmd_i.src_row;
    ref_ra   = cmd_i.ref_row;
    dif_ra   = cmd_i.dif_row;
    src_we   = 1'b0;
    ref_we   = 1'b0;
    dif_we   = 1'b0;
    src_wa   = cur_q.src_row;
    ref_wa   = cur_q.ref_row;
    dif_wa   = cur_q.dif_row;
    src_wd   = bump(src_rd_q, cur_q.src_hi);
    ref_wd   = bump(ref_rd_q, cur_q.ref_hi);
    dif_wd   = bump(dif_rd_q, cur_q.dif_hi);
    sad_clr  = 1'b0;
    sad_add  = 1'b0;
    res_push = 1'b0;
    res_word = '0;
    unique case (state_q)
      ST_CLEAR: begin
        stat_o.clearing = 1'b1;
        clr_d   = clr_q + 1'b1;
        src_we  = ~clr_q[CLR_CNT_W-1];
        ref_we  = ~clr_q[CLR_CNT_W-1];
        dif_we  = 1'b1;
        src_wa  = clr_q[7:0];
        ref_wa  = clr_q[7:0];
        dif_wa  = clr_q;
        src_wd  = '0;
        ref_wd  = '0;
        dif_wd  = '0;
        sad_clr = 1'b1;
      end
      ST_IDLE: begin
        stat_o.cmd_pop = take;
        clr_d = '0;
        if (cmd_i.op == OP_READ) begin
          src_ra = cmd_i.rd_row[7:0];
          ref_ra = cmd_i.rd_row[7:0];
          dif_ra = cmd_i.rd_row;
        end
      end
      ST_UPD: begin
        src_we  = 1'b1;
        ref_we  = 1'b1;
        dif_we  = 1'b1;
        sad_add = 1'b1;
      end
      ST_RD: begin
        res_push = 1'b1;
        case (cur_q.region)
          RG_SRC:  res_word = src_rd_q;
          RG_REF:  res_word = ref_rd_q;
          RG_DIF:  res_word = {dif_rd_q[63:32],
                               cur_q.rd_sad ? sad_q[cur_q.rd_row[8]] : dif_rd_q[31:0]};
          default: res_word = '0;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      sad_q   <= '{default: '0};
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (sad_clr) begin
        sad_q <= '{default: '0};
      end else if (sad_add) begin
        sad_q[cur_q.set] <= sad_q[cur_q.set] + {24'd0, cur_q.abs_diff};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (stat_o.cmd_pop) cur_q <= cmd_i;
  end

  always_ff @(posedge clk_i) begin
    src_rd_q <= src_mem[src_ra];
    if (src_we) src_mem[src_wa] <= src_wd;
  end

  always_ff @(posedge clk_i) begin
    ref_rd_q <= ref_mem[ref_ra];
    if (ref_we) ref_mem[ref_wa] <= ref_wd;
  end

  always_ff @(posedge clk_i) begin
    dif_rd_q <= dif_mem[dif_ra];
    if (dif_we) dif_mem[dif_wa] <= dif_wd;
  end

  // result queue
  assign res_full = (res_cnt_q == ResCntW'(RES_DEPTH));
  assign res_pop  = pop_i & (res_cnt_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_wp_q  <= '0;
      res_rp_q  <= '0;
      res_cnt_q <= '0;
    end else begin
      if (res_push) res_wp_q <= res_wp_q + 1'b1;
      if (res_pop)  res_rp_q <= res_rp_q + 1'b1;
      case ({res_push, res_pop})
        2'b10:   res_cnt_q <= res_cnt_q + 1'b1;
        2'b01:   res_cnt_q <= res_cnt_q - 1'b1;
        default: res_cnt_q <= res_cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) res_q[res_wp_q] <= res_word;
  end

  assign empty_o       = (res_cnt_q == '0);
  assign packed_word_o = res_q[res_rp_q];
  assign res_push_o    = res_push;
  assign res_full_o    = res_full;

endmodule

[sv/frame_histogram_sad_engine_core.sv]
// top level of the frame histogram / sad engine: config registers, front and back parts
// depends on fhs_pkg, fhs_front, fhs_back
//
//  channel  | handshake            | payload
//  input    | push / full          | req_type_i src_sample_i ref_sample_i component_i word_index_i
//  result   | pop / empty          | packed_word_o
//  config   | cfg_we_i             | cfg_idx_i cfg_wdata_i
//
// a sample passes through the back part as a memory read, then an increment write
// a read is a registered memory read, then a result queue write
// a clear request and reset both run a sweep over the difference rows,
// during which full is high; the command queue lets input keep flowing while the
// back part works, and the result queue decouples results from pop
`timescale 1ns / 1ps

module frame_histogram_sad_engine_core import fhs_pkg::*; #(
  parameter int CmdDepth = DEFAULT_CMD_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic        cfg_wdata_i,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  req_type_i,
  input  logic [9:0]  src_sample_i,
  input  logic [9:0]  ref_sample_i,
  input  logic        component_i,
  input  logic [9:0]  word_index_i,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] packed_word_o
);

  logic       ten_q, chroma_q;
  logic       cmd_valid;
  cmd_t       cmd;
  back_stat_t stat;
  logic       res_push, res_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ten_q    <= 1'b0;
      chroma_q <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_TEN_BIT) ten_q    <= cfg_wdata_i;
      if (cfg_idx_i == CFG_CHROMA)  chroma_q <= cfg_wdata_i;
    end
  end

  fhs_front #(.CmdDepth(CmdDepth)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ten_bit_i    (ten_q),
    .chroma_i     (chroma_q),
    .push_i       (push),
    .full_o       (full),
    .req_type_i   (req_type_i),
    .src_sample_i (src_sample_i),
    .ref_sample_i (ref_sample_i),
    .component_i  (component_i),
    .word_index_i (word_index_i),
    .stat_i       (stat),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd)
  );

  fhs_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .empty_o       (empty),
    .pop_i         (pop),
    .packed_word_o (packed_word_o),
    .res_push_o    (res_push),
    .res_full_o    (res_full)
  );

  a_clear_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.clearing |-> full) else $error("input open during clearing sweep");

  a_no_result_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full) else $error("result queue overflow");

  a_pop_needs_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.cmd_pop |-> cmd_valid) else $error("command taken from empty queue");

  a_result_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |=> !empty) else $error("pushed result not visible");

endmodule

[bench/frame_histogram_sad_engine_core_tb.sv]
// testbench for frame_histogram_sad_engine_core: random and directed requests
// with a scoreboard that models the histogram and sad stores; depends on fhs_pkg
`timescale 1ns / 1ps

module frame_histogram_sad_engine_core_tb;
  import fhs_pkg::*;

  class stats_scoreboard;
    logic [31:0] src_bins[2*HIST_BINS];
    logic [31:0] ref_bins[2*HIST_BINS];
    logic [31:0] dif_bins[2*DIFF_BINS];
    logic [31:0] sad_sum[2];
    bit ten_bit;
    bit chroma;
    logic [63:0] pending_words[$];

    function void wipe();
      foreach (src_bins[i]) src_bins[i] = '0;
      foreach (ref_bins[i]) ref_bins[i] = '0;
      foreach (dif_bins[i]) dif_bins[i] = '0;
      sad_sum[0] = '0;
      sad_sum[1] = '0;
    endfunction

    function logic [7:0] narrow(logic [9:0] v);
      logic [10:0] x;
      x = {1'b0, v};
      if (ten_bit) x = (x + 11'd2) >> 2;
      return (x > 11'd255) ? 8'd255 : x[7:0];
    endfunction

    function logic [63:0] packed_at(int w);
      int sets;
      int hw;
      int dw;
      int b;
      int st;
      logic [31:0] lo;
      sets = chroma ? 2 : 1;
      hw = sets * HIST_BINS / 2;
      dw = sets * DIFF_BINS / 2;
      if (w < hw) return {src_bins[2*w+1], src_bins[2*w]};
      w -= hw;
      if (w < hw) return {ref_bins[2*w+1], ref_bins[2*w]};
      w -= hw;
      if (w < dw) begin
        b = 2 * w;
        st = b / DIFF_BINS;
        lo = (b % DIFF_BINS == 0) ? sad_sum[st] : dif_bins[b];
        return {dif_bins[b+1], lo};
      end
      return '0;
    endfunction

    function void note_request(logic [1:0] rt, logic [9:0] s, logic [9:0] r, logic c,
                               logic [9:0] w);
      int st;
      int s8;
      int r8;
      if (rt == REQ_CLEAR) wipe();
      else if (rt == REQ_SAMPLE) begin
        st = chroma ? c : 0;
        s8 = narrow(s);
        r8 = narrow(r);
        src_bins[st*HIST_BINS+s8]++;
        ref_bins[st*HIST_BINS+r8]++;
        dif_bins[st*DIFF_BINS + (s8 - r8 + DIFF_BINS/2)]++;
        sad_sum[st] += (s8 >= r8) ? s8 - r8 : r8 - s8;
      end else if (rt == REQ_READ) pending_words.push_back(packed_at(w));
    endfunction

    function bit check_word(logic [63:0] got, output logic [63:0] want);
      if (pending_words.size() == 0) begin
        want = 'x;
        return 0;
      end
      want = pending_words.pop_front();
      return got === want;
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we_i = 0, cfg_idx_i = 0, cfg_wdata_i = 0;
  logic push = 0, pop = 0;
  logic full, empty;
  logic [1:0] req_type_i = REQ_NONE;
  logic [9:0] src_sample_i = 0, ref_sample_i = 0, word_index_i = 0;
  logic component_i = 0;
  logic [63:0] packed_word_o;

  stats_scoreboard sb = new();
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0, recv_stall_pct = 0;
  bit busy_reads;

  frame_histogram_sad_engine_core uut (.*);

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 400000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(string what);
    errors++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // result side: pop randomly, check on each accepted result
  always @(posedge clk_i) begin
    logic [63:0] want;
    if (rst_ni && pop && !empty) begin
      if (sb.pending_words.size() == 0) report_mismatch("unexpected result");
      else if (!sb.check_word(packed_word_o, want))
        report_mismatch($sformatf("packed_word got %h want %h", packed_word_o, want));
    end
  end

  always @(negedge clk_i)
    pop <= ($urandom_range(99) >= recv_stall_pct);

  task automatic send(logic [1:0] rt, logic [9:0] s, logic [9:0] r, logic c, logic [9:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push <= 1'b1;
    req_type_i <= rt;
    src_sample_i <= s;
    ref_sample_i <= r;
    component_i <= c;
    word_index_i <= w;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sb.note_request(rt, s, r, c, w);
    @(negedge clk_i);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (sb.pending_words.size() != 0) @(negedge clk_i);
    // a trailing sample or clear may still be in the back part
    repeat (600) @(negedge clk_i);
  endtask

  task automatic set_config(bit ten, bit chr);
    drain();
    cfg_we_i <= 1;
    cfg_idx_i <= CFG_TEN_BIT;
    cfg_wdata_i <= ten;
    @(negedge clk_i);
    cfg_idx_i <= CFG_CHROMA;
    cfg_wdata_i <= chr;
    @(negedge clk_i);
    cfg_we_i <= 0;
    sb.ten_bit = ten;
    sb.chroma = chr;
  endtask

  task automatic random_request();
    int k;
    logic [9:0] s, r, w;
    k = $urandom_range(99);
    s = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 10'd1023 : 10'd0) : 10'($urandom);
    r = ($urandom_range(3) == 0) ? (s ^ 10'($urandom_range(7))) : 10'($urandom);
    if (!busy_reads) w = 10'($urandom);
    else w = ($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(767));
    if (k < 1) send(REQ_CLEAR, s, r, 1'($urandom), w);
    else if (k < 3) send(REQ_NONE, s, r, 1'($urandom), w);
    else if (k < (busy_reads ? 45 : 75)) send(REQ_SAMPLE, s, r, 1'($urandom), w);
    else send(REQ_READ, s, r, 1'($urandom), w);
  endtask

  initial begin
    int cfgs[4];
    cfgs = '{0, 3, 1, 2};
    sb.wipe();
    repeat (12) @(negedge clk_i);
    rst_ni <= 1;
    set_config(0, 0);
    // directed: extremes, saturation, rounding, chroma sets, read past layout
    send(REQ_SAMPLE, 10'd0, 10'd0, 0, 0);
    send(REQ_SAMPLE, 10'd1023, 10'd0, 1, 0);
    send(REQ_SAMPLE, 10'd0, 10'd300, 0, 0);
    send(REQ_SAMPLE, 10'd255, 10'd254, 0, 0);
    send(REQ_NONE, 10'd5, 10'd5, 0, 0);
    send(REQ_READ, 0, 0, 0, 10'd0);
    send(REQ_READ, 0, 0, 0, 10'd127);
    send(REQ_READ, 0, 0, 0, 10'd256);
    send(REQ_READ, 0, 0, 0, 10'd383);
    send(REQ_READ, 0, 0, 0, 10'd384);
    send(REQ_READ, 0, 0, 0, 10'd1023);
    set_config(1, 1);
    send(REQ_SAMPLE, 10'd1023, 10'd1, 1, 0);
    send(REQ_SAMPLE, 10'd1021, 10'd2, 0, 0);
    send(REQ_SAMPLE, 10'd6, 10'd1022, 1, 0);
    send(REQ_READ, 0, 0, 0, 10'd255);
    send(REQ_READ, 0, 0, 0, 10'd512);
    send(REQ_READ, 0, 0, 0, 10'd768);
    send(REQ_READ, 0, 0, 0, 10'd1023);
    send(REQ_CLEAR, 0, 0, 0, 0);
    send(REQ_READ, 0, 0, 0, 10'd768);
    for (int ph = 0; ph < 8; ph++) begin
      set_config(cfgs[ph%4][0], cfgs[ph%4][1]);
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 57; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 57; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      busy_reads = ph[0];
      repeat (141) random_request();
    end
    drain();
    if (errors == 0 && sb.pending_words.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

[files.f]
sv/fhs_pkg.sv
sv/fhs_front.sv
sv/fhs_back.sv
sv/frame_histogram_sad_engine_core.sv
bench/frame_histogram_sad_engine_core_tb.sv
